@@ design/cpu_usage_dvfs_governor_defines.svh @@
// Assertion macros for the DVFS governor checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CPU_USAGE_DVFS_GOVERNOR_DEFINES_SVH
`define CPU_USAGE_DVFS_GOVERNOR_DEFINES_SVH

// Same-cycle implication.
`define CUDG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("governor port check failed");

// Next-cycle implication.
`define CUDG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("governor port check failed");

`endif

@@ design/cudg_pkg.sv @@
// Shared types, constants and reset tables for the DVFS governor.
// Used by every module of the block; depends on nothing.
package cudg_pkg;

  localparam int TIME_W        = 48;
  localparam int USAGE_W       = 15;
  localparam int NUM_STATES    = 4;
  localparam int STATE_W       = 2;
  localparam int NUM_CFG_REGS  = 2 * NUM_STATES;
  localparam int CFG_SEL_W     = $clog2(NUM_CFG_REGS);
  localparam int CFG_IDX_W     = CFG_SEL_W + 1;
  localparam int COUNT_W       = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [31:0]          INTERVAL_TICKS = 32'd100000;
  localparam logic [COUNT_W-1:0]   REBUILD_EVALS  = 16'd10;
  localparam logic [STATE_W-1:0]   INITIAL_STATE  = 2'd0;
  localparam logic [USAGE_W-1:0]   FULL_SCALE     = 15'd25600;

  typedef enum logic [CFG_SEL_W-1:0] {
    REG_BAND0_LOW,
    REG_BAND0_HIGH,
    REG_BAND1_LOW,
    REG_BAND1_HIGH,
    REG_BAND2_LOW,
    REG_BAND2_HIGH,
    REG_BAND3_LOW,
    REG_BAND3_HIGH
  } cfg_reg_t;

  typedef struct packed {
    logic              eval;
    logic              zero;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_STALL,
    F_WAIT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_UPD,
    B_SEL
  } back_state_t;

  function automatic logic [USAGE_W-1:0] band_reset(input logic [CFG_SEL_W-1:0] idx);
    logic [USAGE_W-1:0] v;
    unique case (cfg_reg_t'(idx))
      REG_BAND0_LOW:  v = 15'd0;
      REG_BAND0_HIGH: v = 15'd6400;
      REG_BAND1_LOW:  v = 15'd6400;
      REG_BAND1_HIGH: v = 15'd12800;
      REG_BAND2_LOW:  v = 15'd12800;
      REG_BAND2_HIGH: v = 15'd19200;
      REG_BAND3_LOW:  v = 15'd19200;
      REG_BAND3_HIGH: v = 15'd25600;
    endcase
    return v;
  endfunction

endpackage

@@ design/cudg_front.sv @@
// Front end: accepts transaction items, accumulates stall time and decides
// whether an interval has elapsed. Pushes one classified entry per item.
// Depends on cudg_pkg.
module cudg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cudg_pkg::TIME_W-1:0]   issue_time,
  input  logic [cudg_pkg::TIME_W-1:0]   done_time,
  input  logic [cudg_pkg::TIME_W-1:0]   now_time,
  output logic                          push,
  output cudg_pkg::q_entry_t            push_entry,
  input  cudg_pkg::queue_stat_t         qstat
);

  cudg_pkg::front_state_t state, state_next;

  logic [cudg_pkg::TIME_W-1:0] issue_r, done_r, now_r;
  logic [cudg_pkg::TIME_W-1:0] stall_r;
  logic                        eval_r;
  logic [cudg_pkg::TIME_W-1:0] wait_total;
  logic [cudg_pkg::TIME_W:0]   eval_due;
  logic [cudg_pkg::TIME_W:0]   wait_sum;
  logic                        accept;

  always_comb begin
    state_next = state;
    unique case (state)
      cudg_pkg::F_IDLE:  if (accept) state_next = cudg_pkg::F_STALL;
      cudg_pkg::F_STALL: state_next = cudg_pkg::F_WAIT;
      cudg_pkg::F_WAIT:  state_next = cudg_pkg::F_PUSH;
      cudg_pkg::F_PUSH:  if (!qstat.full) state_next = cudg_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != cudg_pkg::F_IDLE);
    accept   = in_valid && !in_stall;
    push     = (state == cudg_pkg::F_PUSH) && !qstat.full;
  end

  assign wait_sum = {1'b0, wait_total} + {1'b0, stall_r};

  assign push_entry.eval = eval_r;
  assign push_entry.zero = (now_r == '0) || (wait_total > now_r);
  assign push_entry.num  = now_r - wait_total;
  assign push_entry.den  = now_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cudg_pkg::F_IDLE;
      wait_total <= '0;
      eval_due   <= (cudg_pkg::TIME_W+1)'(cudg_pkg::INTERVAL_TICKS);
    end else begin
      state <= state_next;
      if (state == cudg_pkg::F_WAIT) begin
        wait_total <= wait_sum[cudg_pkg::TIME_W] ? '1 : wait_sum[cudg_pkg::TIME_W-1:0];
        if (eval_r) begin
          eval_due <= {1'b0, done_r} + (cudg_pkg::TIME_W+1)'(cudg_pkg::INTERVAL_TICKS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      issue_r <= issue_time;
      done_r  <= done_time;
      now_r   <= now_time;
    end
    if (state == cudg_pkg::F_STALL) begin
      stall_r <= (done_r >= issue_r) ? (done_r - issue_r) : '0;
      eval_r  <= ({1'b0, done_r} >= eval_due);
    end
  end

endmodule

@@ design/cudg_queue.sv @@
// Short FIFO of classified items between the front and back ends.
// Depends on cudg_pkg.
module cudg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cudg_pkg::q_entry_t    push_entry,
  input  logic                  pop,
  output cudg_pkg::q_entry_t    head,
  output cudg_pkg::queue_stat_t qstat
);

  localparam int PTR_W = (cudg_pkg::QUEUE_DEPTH > 1) ? $clog2(cudg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cudg_pkg::QUEUE_DEPTH + 1);

  cudg_pkg::q_entry_t entries [cudg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(cudg_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == CNT_W'(cudg_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

endmodule

@@ design/cudg_back.sv @@
// Back end: bit-serial usage divider, min/max tracking, band selection,
// band rebuild and the result register. Holds the band table and its
// configuration port. Depends on cudg_pkg.
module cudg_back (
  input  logic                             clk,
  input  logic                             rst,
  input  cudg_pkg::queue_stat_t            qstat,
  input  cudg_pkg::q_entry_t               head,
  output logic                             pop,
  input  logic                             cfg_write,
  input  logic [cudg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cudg_pkg::USAGE_W-1:0]     cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cudg_pkg::STATE_W-1:0]     power_state,
  output logic                             state_changed,
  output logic                             evaluated,
  output logic [cudg_pkg::USAGE_W-1:0]     usage_percent,
  output logic                             bands_rebuilt
);

  localparam int UW    = cudg_pkg::USAGE_W;
  localparam int TW    = cudg_pkg::TIME_W;
  localparam int STEP_W = $clog2(UW);

  cudg_pkg::back_state_t state, state_next;
  cudg_pkg::q_entry_t    cur;

  logic [TW-1:0]     rem;
  logic [UW-1:0]     lo;
  logic [UW-1:0]     quo;
  logic [STEP_W-1:0] step;
  logic [UW-1:0]     usage_now, usage_min, usage_max;
  logic [UW-1:0]     band_table [cudg_pkg::NUM_CFG_REGS];
  logic [cudg_pkg::STATE_W-1:0] current_state;
  logic [cudg_pkg::COUNT_W-1:0] eval_count;

  logic          fire;
  logic          rebuild;
  logic [TW+4:0] d25;
  logic [TW:0]   trial;
  logic          trial_ge;
  logic [cudg_pkg::NUM_STATES-1:0] in_band;
  logic [cudg_pkg::STATE_W-1:0]    first_hit, new_state;
  logic [UW:0]   mid_sum;
  logic [UW-1:0] h0, h1, h2;

  function automatic logic [UW-1:0] three_quarters(input logic [UW-1:0] x);
    logic [UW+1:0] t;
    t = ({2'b0, x} << 1) + {2'b0, x};
    return t[UW+1:2];
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      cudg_pkg::B_IDLE: begin
        if (!qstat.empty) begin
          if (!head.eval) begin
            state_next = cudg_pkg::B_SEL;
          end else if (head.zero) begin
            state_next = cudg_pkg::B_UPD;
          end else begin
            state_next = cudg_pkg::B_MUL;
          end
        end
      end
      cudg_pkg::B_MUL: state_next = cudg_pkg::B_DIV;
      cudg_pkg::B_DIV: if (step == STEP_W'(UW - 1)) state_next = cudg_pkg::B_UPD;
      cudg_pkg::B_UPD: state_next = cudg_pkg::B_SEL;
      cudg_pkg::B_SEL: if (fire) state_next = cudg_pkg::B_IDLE;
      default:         state_next = cudg_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state == cudg_pkg::B_IDLE) && !qstat.empty;
    fire    = (state == cudg_pkg::B_SEL) && (!out_valid || !out_stall);
    rebuild = fire && cur.eval && (eval_count >= cudg_pkg::REBUILD_EVALS);
  end

  assign d25      = (TW+5)'({cur.num, 4'b0}) + (TW+5)'({cur.num, 3'b0}) + (TW+5)'(cur.num);
  assign trial    = {rem, lo[UW-1]};
  assign trial_ge = (trial >= {1'b0, cur.den});

  always_comb begin
    for (int s = 0; s < cudg_pkg::NUM_STATES; s++) begin
      in_band[s] = (usage_now > band_table[2*s]) && (usage_now <= band_table[2*s+1]);
    end
    first_hit = current_state;
    for (int s = cudg_pkg::NUM_STATES - 1; s >= 0; s--) begin
      if (in_band[s]) first_hit = cudg_pkg::STATE_W'(s);
    end
    if (!cur.eval || in_band[current_state]) begin
      new_state = current_state;
    end else begin
      new_state = first_hit;
    end
  end

  assign mid_sum = {1'b0, usage_min} + {1'b0, usage_max};
  assign h0      = usage_min >> 1;
  assign h1      = usage_min;
  assign h2      = mid_sum[UW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cudg_pkg::B_IDLE;
      out_valid     <= 1'b0;
      usage_now     <= '0;
      usage_min     <= cudg_pkg::FULL_SCALE;
      usage_max     <= '0;
      eval_count    <= '0;
      current_state <= cudg_pkg::INITIAL_STATE;
      for (int i = 0; i < cudg_pkg::NUM_CFG_REGS; i++) begin
        band_table[i] <= cudg_pkg::band_reset(cudg_pkg::CFG_SEL_W'(i));
      end
    end else begin
      state <= state_next;
      if (state == cudg_pkg::B_UPD) begin
        usage_now <= quo;
        if (quo > usage_max) usage_max <= quo;
        if (quo < usage_min) usage_min <= quo;
      end
      if (fire) begin
        out_valid     <= 1'b1;
        current_state <= new_state;
        if (cur.eval) begin
          eval_count <= rebuild ? '0 : eval_count + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (rebuild) begin
        band_table[cudg_pkg::REG_BAND0_LOW]  <= '0;
        band_table[cudg_pkg::REG_BAND0_HIGH] <= h0;
        band_table[cudg_pkg::REG_BAND1_LOW]  <= three_quarters(h0);
        band_table[cudg_pkg::REG_BAND1_HIGH] <= h1;
        band_table[cudg_pkg::REG_BAND2_LOW]  <= three_quarters(h1);
        band_table[cudg_pkg::REG_BAND2_HIGH] <= h2;
        band_table[cudg_pkg::REG_BAND3_LOW]  <= three_quarters(h2);
        band_table[cudg_pkg::REG_BAND3_HIGH] <= cudg_pkg::FULL_SCALE;
        usage_min <= cudg_pkg::FULL_SCALE;
        usage_max <= '0;
      end else if (cfg_write &&
                   (cfg_index < cudg_pkg::CFG_IDX_W'(cudg_pkg::NUM_CFG_REGS))) begin
        band_table[cfg_index[cudg_pkg::CFG_SEL_W-1:0]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (pop && head.zero) quo <= '0;
    if (state == cudg_pkg::B_MUL) begin
      rem  <= d25[TW+4:5];
      lo   <= {d25[4:0], 10'b0};
      step <= '0;
    end
    if (state == cudg_pkg::B_DIV) begin
      rem  <= trial_ge ? TW'(trial - {1'b0, cur.den}) : trial[TW-1:0];
      lo   <= lo << 1;
      quo  <= {quo[UW-2:0], trial_ge};
      step <= step + 1'b1;
    end
    if (fire) begin
      power_state   <= new_state;
      state_changed <= (new_state != current_state);
      evaluated     <= cur.eval;
      usage_percent <= usage_now;
      bands_rebuilt <= rebuild;
    end
  end

endmodule

@@ design/cpu_usage_dvfs_governor.sv @@
// Top level of the utilization-threshold DVFS governor.
// Instantiates cudg_front, cudg_queue and cudg_back; depends on cudg_pkg.
//
// Each input item is one completed memory transaction and yields exactly one
// result item. The front end takes no new item until the last one is pushed:
// it folds the stall time into a saturating 48-bit wait total and checks the
// interval clock in a three-step sequence. A two-entry queue then hands the
// item to the back end. An item that does not end an interval goes straight to
// band selection; an evaluating item passes the multiply step, the bit-serial
// divider that forms busy percent as (now - wait) * 25600 / now in Q7.8, the
// update step and band selection, and skips multiply and divide when usage is
// forced to zero. Results wait in an output register, so the front end keeps
// taking items while a result is stalled until the queue is full. The band
// registers written through cfg_write/cfg_index/cfg_data load the live band
// table at once unless a rebuild takes priority; indexes 8 and up are ignored.
module cpu_usage_dvfs_governor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cudg_pkg::TIME_W-1:0]      issue_time,
  input  logic [cudg_pkg::TIME_W-1:0]      done_time,
  input  logic [cudg_pkg::TIME_W-1:0]      now_time,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cudg_pkg::STATE_W-1:0]     power_state,
  output logic                             state_changed,
  output logic                             evaluated,
  output logic [cudg_pkg::USAGE_W-1:0]     usage_percent,
  output logic                             bands_rebuilt,
  input  logic                             cfg_write,
  input  logic [cudg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cudg_pkg::USAGE_W-1:0]     cfg_data
);

  logic                  push, pop;
  cudg_pkg::q_entry_t    push_entry, head;
  cudg_pkg::queue_stat_t qstat;

  cudg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .issue_time (issue_time),
    .done_time  (done_time),
    .now_time   (now_time),
    .push       (push),
    .push_entry (push_entry),
    .qstat      (qstat)
  );

  cudg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  cudg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .head          (head),
    .pop           (pop),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .power_state   (power_state),
    .state_changed (state_changed),
    .evaluated     (evaluated),
    .usage_percent (usage_percent),
    .bands_rebuilt (bands_rebuilt)
  );

endmodule

@@ design/cudg_checker.sv @@
// Port-level checks for the DVFS governor, bound to the top level.
// Depends on cudg_pkg and cpu_usage_dvfs_governor_defines.svh.
`include "cpu_usage_dvfs_governor_defines.svh"

module cudg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cudg_pkg::STATE_W-1:0]   power_state,
  input logic                           state_changed,
  input logic                           evaluated,
  input logic [cudg_pkg::USAGE_W-1:0]   usage_percent,
  input logic                           bands_rebuilt
);

  `CUDG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(power_state) && $stable(usage_percent))
  `CUDG_ASSERT_IMP(a_change_needs_eval, out_valid && state_changed, evaluated)
  `CUDG_ASSERT_IMP(a_rebuild_needs_eval, out_valid && bands_rebuilt, evaluated)
  `CUDG_ASSERT_IMP(a_usage_range, out_valid, usage_percent <= cudg_pkg::FULL_SCALE)

endmodule

bind cpu_usage_dvfs_governor cudg_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .power_state   (power_state),
  .state_changed (state_changed),
  .evaluated     (evaluated),
  .usage_percent (usage_percent),
  .bands_rebuilt (bands_rebuilt)
);

@@ tb/governor_checker.sv @@
// Checker for the DVFS governor: watches the input, output and band register ports,
// predicts every result item from the transaction times it accepts, and counts mismatches.
// Depends on cudg_pkg for widths, register names and the interval and rebuild constants.
`timescale 1ns / 1ps

module governor_checker
  import cudg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TIME_W-1:0]    issue_time,
  input  logic [TIME_W-1:0]    done_time,
  input  logic [TIME_W-1:0]    now_time,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [STATE_W-1:0]   power_state,
  input  logic                 state_changed,
  input  logic                 evaluated,
  input  logic [USAGE_W-1:0]   usage_percent,
  input  logic                 bands_rebuilt,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [USAGE_W-1:0]   cfg_data,
  output int unsigned          pending,
  output int unsigned          mismatches
);

  typedef struct packed {
    logic [STATE_W-1:0] power_state;
    logic               state_changed;
    logic               evaluated;
    logic [USAGE_W-1:0] usage_percent;
    logic               bands_rebuilt;
  } decision_t;

  localparam logic [63:0]        WAIT_CEILING = (64'd1 << TIME_W) - 64'd1;
  localparam logic [USAGE_W-1:0] QUARTER      = FULL_SCALE / 4;

  logic [TIME_W-1:0]  wait_sum;
  logic [TIME_W-1:0]  last_eval_at;
  logic [COUNT_W-1:0] eval_tally;
  logic [USAGE_W-1:0] busy_now;
  logic [USAGE_W-1:0] busy_min;
  logic [USAGE_W-1:0] busy_max;
  logic [USAGE_W-1:0] band_bound [NUM_CFG_REGS];
  logic [STATE_W-1:0] level;
  decision_t          queued_decisions [$];

  function automatic void reset_governor();
    for (int s = 0; s < NUM_STATES; s++) begin
      band_bound[2*s]   = USAGE_W'(s * QUARTER);
      band_bound[2*s+1] = USAGE_W'((s + 1) * QUARTER);
    end
    wait_sum = '0;
    last_eval_at = '0;
    eval_tally = '0;
    busy_now = '0;
    busy_min = FULL_SCALE;
    busy_max = '0;
    level = INITIAL_STATE;
  endfunction

  function automatic logic holds(input int s, input logic [USAGE_W-1:0] u);
    return (u > band_bound[2*s]) && (u <= band_bound[2*s+1]);
  endfunction

  function automatic logic [USAGE_W-1:0] three_quarters(input logic [USAGE_W-1:0] x);
    logic [USAGE_W+1:0] tripled;
    tripled = (USAGE_W+2)'(x) * (USAGE_W+2)'(3);
    return tripled[USAGE_W+1:2];
  endfunction

  function automatic void rebuild_bands();
    logic [USAGE_W-1:0] h0;
    logic [USAGE_W-1:0] h1;
    logic [USAGE_W:0]   mid;
    h0 = busy_min >> 1;
    h1 = busy_min;
    mid = {1'b0, busy_min} + {1'b0, busy_max};
    band_bound[REG_BAND0_LOW]  = '0;
    band_bound[REG_BAND0_HIGH] = h0;
    band_bound[REG_BAND1_LOW]  = three_quarters(h0);
    band_bound[REG_BAND1_HIGH] = h1;
    band_bound[REG_BAND2_LOW]  = three_quarters(h1);
    band_bound[REG_BAND2_HIGH] = mid[USAGE_W:1];
    band_bound[REG_BAND3_LOW]  = three_quarters(mid[USAGE_W:1]);
    band_bound[REG_BAND3_HIGH] = FULL_SCALE;
    busy_min = FULL_SCALE;
    busy_max = '0;
  endfunction

  function automatic decision_t predict_decision(input logic [TIME_W-1:0] iss,
                                                 input logic [TIME_W-1:0] dn,
                                                 input logic [TIME_W-1:0] nw);
    logic [63:0]        stall;
    logic [63:0]        total;
    logic [63:0]        ratio;
    logic [STATE_W-1:0] prior;
    logic               moved;
    decision_t          d;
    prior = level;
    d = '0;
    stall = (dn >= iss) ? 64'(dn - iss) : 64'd0;
    total = 64'(wait_sum) + stall;
    wait_sum = (total > WAIT_CEILING) ? WAIT_CEILING[TIME_W-1:0] : total[TIME_W-1:0];
    if (64'(dn) >= 64'(last_eval_at) + 64'(INTERVAL_TICKS)) begin
      last_eval_at = dn;
      d.evaluated = 1'b1;
      if (nw == '0 || wait_sum > nw) begin
        busy_now = '0;
      end else begin
        ratio = (64'(nw - wait_sum) * 64'(FULL_SCALE)) / 64'(nw);
        busy_now = ratio[USAGE_W-1:0];
      end
      if (busy_now > busy_max) busy_max = busy_now;
      if (busy_now < busy_min) busy_min = busy_now;
      if (!holds(level, busy_now)) begin
        moved = 1'b0;
        for (int s = 0; s < NUM_STATES; s++) begin
          if (!moved && holds(s, busy_now)) begin
            level = STATE_W'(s);
            moved = 1'b1;
          end
        end
      end
      if (eval_tally >= REBUILD_EVALS) begin
        eval_tally = '0;
        rebuild_bands();
        d.bands_rebuilt = 1'b1;
      end else begin
        eval_tally = eval_tally + 1'b1;
      end
    end
    d.power_state = level;
    d.state_changed = (level != prior);
    d.usage_percent = busy_now;
    return d;
  endfunction

  function automatic void check_field(input string name, input logic [USAGE_W-1:0] want,
                                      input logic [USAGE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      reset_governor();
      queued_decisions.delete();
    end else begin
      if (cfg_write && cfg_index < NUM_CFG_REGS) begin
        band_bound[cfg_index[CFG_SEL_W-1:0]] = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (queued_decisions.size() == 0) begin
          $error("result item arrived with nothing expected");
          mismatches++;
        end else begin
          want = queued_decisions.pop_front();
          check_field("power_state", want.power_state, power_state);
          check_field("state_changed", want.state_changed, state_changed);
          check_field("evaluated", want.evaluated, evaluated);
          check_field("usage_percent", want.usage_percent, usage_percent);
          check_field("bands_rebuilt", want.bands_rebuilt, bands_rebuilt);
        end
      end
      if (in_valid && !in_stall) begin
        queued_decisions.push_back(predict_decision(issue_time, done_time, now_time));
      end
    end
    pending = queued_decisions.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the DVFS governor testbench: clock, reset, transaction stimulus and band settings.
// Instantiates cpu_usage_dvfs_governor and governor_checker; depends on cudg_pkg.
`timescale 1ns / 1ps

module tb;
  import cudg_pkg::*;

  typedef enum int {
    BANDS_SPLIT,
    BANDS_WIDE_OPEN,
    BANDS_CLOSED,
    BANDS_RANDOM,
    BANDS_DEFAULT,
    BANDS_GAPPED
  } band_setting_t;

  localparam int unsigned        CYCLE_LIMIT  = 800000;
  localparam int unsigned        HOLD_CYCLES  = 300;
  localparam int unsigned        PHASE_ITEMS  = 325;
  localparam int                 NUM_PHASES   = 6;
  localparam logic [TIME_W-1:0]  TIME_MAX     = '1;
  localparam logic [TIME_W-1:0]  IVL          = TIME_W'(INTERVAL_TICKS);
  localparam logic [USAGE_W-1:0] BOUND_MAX    = '1;
  localparam logic [USAGE_W-1:0] QUARTER      = FULL_SCALE / 4;
  localparam int unsigned        SPARE_FIRST  = NUM_CFG_REGS;
  localparam int unsigned        SPARE_LAST   = (1 << CFG_IDX_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic [TIME_W-1:0]    issue_time = '0;
  logic [TIME_W-1:0]    done_time = '0;
  logic [TIME_W-1:0]    now_time = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [USAGE_W-1:0]   cfg_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [STATE_W-1:0]   power_state;
  logic                 state_changed;
  logic                 evaluated;
  logic [USAGE_W-1:0]   usage_percent;
  logic                 bands_rebuilt;
  int unsigned          pending;
  int unsigned          mismatches;

  int unsigned          cycles = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  logic                 hold_go = 1'b0;
  logic                 hold_seen = 1'b0;
  int unsigned          hold_left = 0;
  logic [63:0]          tick = '0;
  logic [63:0]          sent_wait = '0;
  logic [63:0]          eval_mark = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpu_usage_dvfs_governor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .issue_time(issue_time), .done_time(done_time), .now_time(now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .power_state(power_state), .state_changed(state_changed), .evaluated(evaluated),
    .usage_percent(usage_percent), .bands_rebuilt(bands_rebuilt),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  governor_checker gov_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .issue_time(issue_time), .done_time(done_time), .now_time(now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .power_state(power_state), .state_changed(state_changed), .evaluated(evaluated),
    .usage_percent(usage_percent), .bands_rebuilt(bands_rebuilt),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatches)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic logic [TIME_W-1:0] rand_ticks();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  task automatic offer_txn(input logic [TIME_W-1:0] iss, input logic [TIME_W-1:0] dn,
                           input logic [TIME_W-1:0] nw);
    logic [63:0] stall;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    issue_time <= iss;
    done_time <= dn;
    now_time <= nw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stall = (dn >= iss) ? 64'(dn - iss) : 64'd0;
    sent_wait = (sent_wait + stall > 64'(TIME_MAX)) ? 64'(TIME_MAX) : sent_wait + stall;
    if (64'(dn) >= eval_mark + 64'(INTERVAL_TICKS)) eval_mark = 64'(dn);
    if (64'(dn) > tick) tick = 64'(dn);
  endtask

  // A transaction that advances time; now_time is placed against the running wait
  // total so that the busy percent lands near the level that load selects.
  task automatic offer_busy_txn(input int unsigned load);
    logic [63:0] dn;
    logic [63:0] iss;
    logic [63:0] nw;
    logic [63:0] w;
    int unsigned pick;
    int unsigned m;
    pick = $urandom_range(0, 15);
    if (pick == 0 && tick < eval_mark + 64'(INTERVAL_TICKS)) begin
      dn = eval_mark + 64'(INTERVAL_TICKS) - $urandom_range(0, 1);
    end else begin
      dn = tick + $urandom_range(1000, 60000);
    end
    if (pick == 1) iss = dn + $urandom_range(1, 5000);
    else iss = dn - $urandom_range(0, 32'(dn - tick));
    w = sent_wait + ((iss <= dn) ? dn - iss : 64'd0);
    m = load + $urandom_range(0, 4);
    case (pick)
      2: nw = '0;
      3: nw = (w > 0) ? w - 1 : '0;
      4: nw = w;
      5: nw = 64'(rand_ticks());
      default: nw = w + (((w + 1) * m) >> 4);
    endcase
    offer_txn(iss[TIME_W-1:0], dn[TIME_W-1:0], nw[TIME_W-1:0]);
  endtask

  task automatic offer_noise_txn();
    logic [63:0] dn;
    dn = (tick > 5000) ? tick - $urandom_range(0, 5000) : tick;
    if ($urandom_range(0, 7) == 0) dn = '0;
    offer_txn(rand_ticks(), dn[TIME_W-1:0], ($urandom_range(0, 7) == 0) ? '0 : rand_ticks());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_bands(input band_setting_t kind);
    logic [USAGE_W-1:0] bound_val [NUM_CFG_REGS];
    int unsigned c1;
    int unsigned c2;
    int unsigned c3;
    int unsigned lo;
    c1 = $urandom_range(100, 8000);
    c2 = $urandom_range(c1 + 1, 16000);
    c3 = $urandom_range(c2 + 1, 25500);
    for (int s = 0; s < NUM_STATES; s++) begin
      case (kind)
        BANDS_SPLIT: begin
          bound_val[2*s] = '0;
          bound_val[2*s+1] = FULL_SCALE;
        end
        BANDS_WIDE_OPEN: begin
          bound_val[2*s] = '0;
          bound_val[2*s+1] = BOUND_MAX;
        end
        BANDS_CLOSED: begin
          bound_val[2*s] = BOUND_MAX;
          bound_val[2*s+1] = '0;
        end
        BANDS_RANDOM: begin
          bound_val[2*s] = USAGE_W'($urandom_range(0, BOUND_MAX));
          bound_val[2*s+1] = USAGE_W'($urandom_range(0, BOUND_MAX));
        end
        BANDS_DEFAULT: begin
          bound_val[2*s] = USAGE_W'(s * QUARTER);
          bound_val[2*s+1] = USAGE_W'((s + 1) * QUARTER);
        end
        default: begin
          lo = s * QUARTER + $urandom_range(0, QUARTER / 2);
          bound_val[2*s] = USAGE_W'(lo);
          bound_val[2*s+1] = USAGE_W'(lo + $urandom_range(0, QUARTER / 2));
        end
      endcase
    end
    if (kind == BANDS_SPLIT) begin
      bound_val[REG_BAND0_HIGH] = USAGE_W'(c1);
      bound_val[REG_BAND1_LOW] = USAGE_W'(c1);
      bound_val[REG_BAND1_HIGH] = USAGE_W'(c2);
      bound_val[REG_BAND2_LOW] = USAGE_W'(c2);
      bound_val[REG_BAND2_HIGH] = USAGE_W'(c3);
      bound_val[REG_BAND3_LOW] = USAGE_W'(c3);
    end
    for (int r = 0; r < NUM_CFG_REGS; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= bound_val[r];
      @(posedge clk);
    end
    // An index past the band registers must leave the table alone.
    cfg_write <= 1'b1;
    cfg_index <= CFG_IDX_W'($urandom_range(SPARE_FIRST, SPARE_LAST));
    cfg_data <= USAGE_W'($urandom_range(0, BOUND_MAX));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned load;
    load = 0;
    send_idle_pct = 6;
    recv_stall_pct <= 80;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // First evaluation with no stall gives full scale and lands in the top band.
    offer_txn(IVL, IVL, 2 * IVL);
    offer_txn('0, '0, '0);
    offer_txn(IVL, 2 * IVL - 1, '0);
    offer_txn(2 * IVL, 2 * IVL, '0);
    offer_txn(3 * IVL, 3 * IVL, IVL / 2);
    offer_txn(4 * IVL, 4 * IVL, IVL - 1);
    // Response before issue; usage is exactly the top of band two.
    offer_txn(TIME_MAX, 5 * IVL, 4 * (IVL - 1));
    offer_txn(6 * IVL - 1, 6 * IVL, TIME_MAX);
    for (int j = 0; j < 6; j++) begin
      offer_txn((7 + j) * IVL, (7 + j) * IVL, IVL + ((IVL * (1 << (2 * j))) >> 4));
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 6;
        recv_stall_pct <= 80;
      end else if (p < 4) begin
        send_idle_pct = 80;
        recv_stall_pct <= 6;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      write_bands(band_setting_t'(p));
      if (p == 4) hold_go <= ~hold_go;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 30 == 0) load = $urandom_range(0, 1 << $urandom_range(0, 12));
        if ($urandom_range(0, 9) == 0) offer_noise_txn();
        else offer_busy_txn(load);
      end
      drain();
    end

    // Full-range times last: they end evaluations and saturate the wait total for good.
    for (int j = 0; j < 8; j++) begin
      offer_txn(rand_ticks(), rand_ticks(), rand_ticks());
    end
    offer_txn('0, TIME_MAX, TIME_MAX);
    offer_txn('0, TIME_MAX, rand_ticks());
    offer_txn(TIME_MAX, TIME_MAX, TIME_MAX);
    drain();
    repeat (40) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
